/* rtl/core/cfo_rot_pkg.sv */
// shared types, constants and rounding helpers for the cfo phase rotator
package cfo_rot_pkg;

    // number formats
    localparam int SMP_W    = 16;
    localparam int PH_FRAC  = 16;
    localparam int PH_W     = PH_FRAC + 2;
    localparam int PROD_W   = 2 * PH_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int RND_W    = SUM_W - PH_FRAC;
    localparam int TILE_LEN = 4096;
    localparam int POS_W    = $clog2(TILE_LEN);

    localparam logic signed [PH_W-1:0]  PH_ONE     = PH_W'(1 << PH_FRAC);
    localparam logic signed [PH_W-1:0]  PH_ZERO    = '0;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (PH_FRAC - 1));
    localparam logic [POS_W-1:0]        POS_LAST   = POS_W'(TILE_LEN - 1);

    // saturation bounds in rounded-sum width
    localparam logic signed [RND_W-1:0] PH_MAX  = RND_W'((1 << (PH_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] PH_MIN  = -RND_W'(1 << (PH_W - 1));
    localparam logic signed [RND_W-1:0] SMP_MAX = RND_W'((1 << (SMP_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] SMP_MIN = -RND_W'(1 << (SMP_W - 1));

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_COS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_SIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_STEP_COS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_STEP_SIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_COS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_SIN     = 3'd5;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample_re;
        logic signed [SMP_W-1:0] sample_im;
        logic                    frame_last;
    } sample_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_re;
        logic signed [SMP_W-1:0] out_im;
        logic                    out_last;
    } result_t;

    // complex product selected on the shared multiplier
    typedef enum logic [1:0] {
        OP_COMP = 2'd0,
        OP_OUT  = 2'd1,
        OP_BASE = 2'd2,
        OP_TILE = 2'd3
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load_sample;
        logic mul_en;
        logic sum_en;
        logic out_load;
        logic frame_end;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic tile_wrap;
        logic out_free;
    } status_t;

    // round to nearest, ties up, then drop the fraction bits
    function automatic logic signed [RND_W-1:0] round_prod(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v + ROUND_HALF;
        return t[SUM_W-1:PH_FRAC];
    endfunction

    function automatic logic signed [PH_W-1:0] sat_ph(input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] c;
        c = (v > PH_MAX) ? PH_MAX : ((v < PH_MIN) ? PH_MIN : v);
        return c[PH_W-1:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [RND_W-1:0] v);
        logic signed [RND_W-1:0] c;
        c = (v > SMP_MAX) ? SMP_MAX : ((v < SMP_MIN) ? SMP_MIN : v);
        return c[SMP_W-1:0];
    endfunction

endpackage

/* rtl/core/cfo_rot_ctrl.sv */
// sequencer for the cfo phase rotator: steps the shared complex multiplier
module cfo_rot_ctrl
    import cfo_rot_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_MUL_COMP = 9'b000000010,
        ST_SUM_COMP = 9'b000000100,
        ST_MUL_OUT  = 9'b000001000,
        ST_SUM_OUT  = 9'b000010000,
        ST_MUL_BASE = 9'b000100000,
        ST_SUM_BASE = 9'b001000000,
        ST_MUL_TILE = 9'b010000000,
        ST_SUM_TILE = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign sample_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.op          = OP_COMP;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_MUL_COMP;
                end
            end
            ST_MUL_COMP:
            begin
                cmd.op     = OP_COMP;
                cmd.mul_en = 1'b1;
                state_next = ST_SUM_COMP;
            end
            ST_SUM_COMP:
            begin
                cmd.op     = OP_COMP;
                cmd.sum_en = 1'b1;
                state_next = ST_MUL_OUT;
            end
            ST_MUL_OUT:
            begin
                cmd.op     = OP_OUT;
                cmd.mul_en = 1'b1;
                state_next = ST_SUM_OUT;
            end
            ST_SUM_OUT:
            begin
                cmd.op = OP_OUT;
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.last)
                    begin
                        cmd.frame_end = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_MUL_BASE;
                    end
                end
            end
            ST_MUL_BASE:
            begin
                cmd.op     = OP_BASE;
                cmd.mul_en = 1'b1;
                state_next = ST_SUM_BASE;
            end
            ST_SUM_BASE:
            begin
                cmd.op     = OP_BASE;
                cmd.sum_en = 1'b1;
                state_next = status.tile_wrap ? ST_MUL_TILE : ST_IDLE;
            end
            ST_MUL_TILE:
            begin
                cmd.op     = OP_TILE;
                cmd.mul_en = 1'b1;
                state_next = ST_SUM_TILE;
            end
            ST_SUM_TILE:
            begin
                cmd.op     = OP_TILE;
                cmd.sum_en = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/cfo_rot_dp.sv */
// datapath for the cfo phase rotator: phasor state, shared complex multiplier, output register
module cfo_rot_dp
    import cfo_rot_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sample_t              sample,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PH_W-1:0]      cfg_data,
    output result_t              result,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  cmd_t                 cmd,
    output status_t              status
);

    // configuration
    logic signed [PH_W-1:0] delta_cos_reg, delta_sin_reg;
    logic signed [PH_W-1:0] step_cos_reg, step_sin_reg;
    logic signed [PH_W-1:0] start_cos_reg, start_sin_reg;

    // phasor state
    logic signed [PH_W-1:0] base_re_reg, base_im_reg;
    logic signed [PH_W-1:0] tile_re_reg, tile_im_reg;
    logic signed [PH_W-1:0] comp_re_reg, comp_im_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   frame_start_reg;
    sample_t                sample_reg;

    // multiplier pipeline
    logic signed [PH_W-1:0]   a_re, a_im, b_re, b_im;
    logic signed [PROD_W-1:0] prod_rr_reg, prod_ii_reg, prod_ri_reg, prod_ir_reg;
    logic signed [SUM_W-1:0]  sum_re, sum_im;
    logic signed [RND_W-1:0]  rnd_re, rnd_im;

    result_t result_reg;
    logic    result_valid_reg;

    // operand selection
    always_comb
    begin
        case (cmd.op)
            OP_COMP:
            begin
                a_re = base_re_reg;  a_im = base_im_reg;
                b_re = tile_re_reg;  b_im = tile_im_reg;
            end
            OP_OUT:
            begin
                a_re = PH_W'(sample_reg.sample_re);
                a_im = PH_W'(sample_reg.sample_im);
                b_re = comp_re_reg;  b_im = comp_im_reg;
            end
            OP_BASE:
            begin
                a_re = base_re_reg;    a_im = base_im_reg;
                b_re = delta_cos_reg;  b_im = delta_sin_reg;
            end
            OP_TILE:
            begin
                a_re = tile_re_reg;   a_im = tile_im_reg;
                b_re = step_cos_reg;  b_im = step_sin_reg;
            end
            default:
            begin
                a_re = base_re_reg;  a_im = base_im_reg;
                b_re = tile_re_reg;  b_im = tile_im_reg;
            end
        endcase
    end

    // partial products
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_rr_reg <= a_re * b_re;
            prod_ii_reg <= a_im * b_im;
            prod_ri_reg <= a_re * b_im;
            prod_ir_reg <= a_im * b_re;
        end
    end

    // combine and round
    assign sum_re = SUM_W'(prod_rr_reg) - SUM_W'(prod_ii_reg);
    assign sum_im = SUM_W'(prod_ri_reg) + SUM_W'(prod_ir_reg);
    assign rnd_re = round_prod(sum_re);
    assign rnd_im = round_prod(sum_im);

    assign status.last      = sample_reg.frame_last;
    assign status.tile_wrap = (pos_reg == POS_LAST);
    assign status.out_free  = !result_valid_reg || !result_stall;

    // sample capture and rotated phasor
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            sample_reg <= sample;
        end
        if (cmd.sum_en && cmd.op == OP_COMP)
        begin
            comp_re_reg <= sat_ph(rnd_re);
            comp_im_reg <= sat_ph(rnd_im);
        end
        if (cmd.out_load)
        begin
            result_reg.out_re   <= sat_smp(rnd_re);
            result_reg.out_im   <= sat_smp(rnd_im);
            result_reg.out_last <= sample_reg.frame_last;
        end
    end

    // configuration, phasor state and tile position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_cos_reg   <= PH_ONE;
            delta_sin_reg   <= PH_ZERO;
            step_cos_reg    <= PH_ONE;
            step_sin_reg    <= PH_ZERO;
            start_cos_reg   <= PH_ONE;
            start_sin_reg   <= PH_ZERO;
            base_re_reg     <= PH_ONE;
            base_im_reg     <= PH_ZERO;
            tile_re_reg     <= PH_ONE;
            tile_im_reg     <= PH_ZERO;
            pos_reg         <= '0;
            frame_start_reg <= 1'b1;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_DELTA_COS:     delta_cos_reg <= cfg_data;
                    REG_DELTA_SIN:     delta_sin_reg <= cfg_data;
                    REG_TILE_STEP_COS: step_cos_reg  <= cfg_data;
                    REG_TILE_STEP_SIN: step_sin_reg  <= cfg_data;
                    REG_START_COS:
                    begin
                        start_cos_reg <= cfg_data;
                        if (frame_start_reg)
                        begin
                            tile_re_reg <= cfg_data;
                        end
                    end
                    REG_START_SIN:
                    begin
                        start_sin_reg <= cfg_data;
                        if (frame_start_reg)
                        begin
                            tile_im_reg <= cfg_data;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.load_sample)
            begin
                frame_start_reg <= 1'b0;
            end

            // frame end restarts both phasors
            if (cmd.frame_end)
            begin
                base_re_reg     <= PH_ONE;
                base_im_reg     <= PH_ZERO;
                tile_re_reg     <= start_cos_reg;
                tile_im_reg     <= start_sin_reg;
                pos_reg         <= '0;
                frame_start_reg <= 1'b1;
            end

            if (cmd.sum_en)
            begin
                case (cmd.op)
                    OP_BASE:
                    begin
                        if (pos_reg == POS_LAST)
                        begin
                            base_re_reg <= PH_ONE;
                            base_im_reg <= PH_ZERO;
                            pos_reg     <= '0;
                        end
                        else
                        begin
                            base_re_reg <= sat_ph(rnd_re);
                            base_im_reg <= sat_ph(rnd_im);
                            pos_reg     <= pos_reg + 1'b1;
                        end
                    end
                    OP_TILE:
                    begin
                        tile_re_reg <= sat_ph(rnd_re);
                        tile_im_reg <= sat_ph(rnd_im);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

/* rtl/core/cfo_phase_rotator_core.sv */
// top level of the cfo phase rotator: sequencer plus datapath
//
// Rotates each complex Q1.15 sample by base * tile phasor (both Q2.16), with round-to-nearest
// and saturation on every product. The base phasor steps by delta each sample and returns to
// 1.0 every 4096 samples, when the tile phasor steps by tile_step; a sample flagged frame_last
// reloads the start phasor after it is rotated. One complex multiplier (four 18x18 products
// and a rounding adder) runs every product as a multiply step then a sum step: base * tile,
// sample * that phasor, base * delta, then tile * tile_step at a tile boundary; a frame_last
// item ends after its output product. A sample is taken only in idle; the output step waits
// while result_stall holds a full result register, which keeps a finished sample while the
// phasor update of that sample goes ahead. Configuration writes are always ready; start_cos
// and start_sin written between frames take effect from the first sample of the next frame.
module cfo_phase_rotator_core
    import cfo_rot_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sample_t              sample,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    output result_t              result,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PH_W-1:0]      cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    cfo_rot_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // datapath
    cfo_rot_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

/* rtl/core/cfo_rot_checker.sv */
// port-level checks for the cfo phase rotator, bound to the top level
module cfo_rot_checker
    import cfo_rot_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_valid,
    input logic    sample_stall,
    input result_t result,
    input logic    result_valid,
    input logic    result_stall
);

    // a stalled result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // an accepted transfer keeps the input stalled while the first products run
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall ##1 sample_stall)
        else $error("input taken again before the rotation finished");

    // a new result comes only out of an item in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
        else $error("result appeared with no item in work");

endmodule

bind cfo_phase_rotator_core cfo_rot_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);
